### design/sbs_pkg.sv
// ----------------------------------------------------------------------------
// sbs_pkg: shared types and constants
// Function and result codes, register map, default sizes, ASCII folding.
// ----------------------------------------------------------------------------
package sbs_pkg;

    localparam int SBS_PATTERN_MAX   = 64;
    localparam int SBS_POSITION_BITS = 32;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_CLEAR = 2'd0;
    localparam func_t FUNC_PAT   = 2'd1;
    localparam func_t FUNC_TEXT  = 2'd2;
    localparam func_t FUNC_END   = 2'd3;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_SINGLE = 2'd0;
    localparam kind_t KIND_HIT    = 2'd1;
    localparam kind_t KIND_DONE   = 2'd2;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_MODE    = 3'd0;
    localparam reg_idx_t REG_CURSOR  = 3'd1;
    localparam reg_idx_t REG_FORWARD = 3'd2;
    localparam reg_idx_t REG_WRAP    = 3'd3;
    localparam reg_idx_t REG_RSTART  = 3'd4;
    localparam reg_idx_t REG_REND    = 3'd5;
    localparam reg_idx_t REG_MAXHITS = 3'd6;

    function automatic logic is_upper(input logic [7:0] c);
        is_upper = (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        fold = is_upper(c) ? (c + 8'd32) : c;
    endfunction

endpackage

### design/sbs_cell.sv
// ----------------------------------------------------------------------------
// sbs_cell: one slot of the search chain
// Holds one pattern byte and one text byte, both shifting to the next cell,
// and compares them with optional ASCII case folding.
// ----------------------------------------------------------------------------
module sbs_cell
(
    input  logic       clk,
    input  logic       pat_shift,
    input  logic [7:0] pat_in,
    input  logic       win_shift,
    input  logic [7:0] win_in,
    input  logic       active,
    input  logic       case_sens,
    output logic [7:0] pat_out,
    output logic [7:0] win_out,
    output logic       eq
);
    import sbs_pkg::*;

    logic [7:0] pat_reg;
    logic [7:0] win_reg;

    always_ff @(posedge clk)
    begin
        if (pat_shift)
        begin
            pat_reg <= pat_in;
        end
        if (win_shift)
        begin
            win_reg <= win_in;
        end
    end

    assign pat_out = pat_reg;
    assign win_out = win_reg;
    // slots beyond the pattern length always agree
    assign eq = !active ||
                (case_sens ? (pat_reg == win_reg) : (fold(pat_reg) == fold(win_reg)));

endmodule

### design/smartcase_buffer_search.sv
// ----------------------------------------------------------------------------
// smartcase_buffer_search: streaming smartcase substring search
// Pattern and text bytes shift through a chain of compare cells; matches
// feed next/previous candidates or find-all hits.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle, with or without a result, unless m_tready stalls.
// Pipeline: an accepted beat is registered in the front stage, then its result
//   in the result register; cell compare and AND reduction lie between them.
// Reset: rst_n clears control, registers to defaults, pattern length, text
//   position, candidates, hit count and overflow; cell data is not reset.
module smartcase_buffer_search
#(
    parameter int PATTERN_MAX   = sbs_pkg::SBS_PATTERN_MAX,
    parameter int POSITION_BITS = sbs_pkg::SBS_POSITION_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // found, wrapped, match_start[31:0],
                                   // match_end[31:0], hit_count[15:0], overflow
    output logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sbs_pkg::*;

    localparam int LW = $clog2(PATTERN_MAX + 1);
    localparam int PW = POSITION_BITS;
    localparam int CW = (PW > 32) ? PW : 32;

    // configuration
    logic        mode_reg;
    logic [31:0] cursor_reg;
    logic        fwd_reg;
    logic        wrap_reg;
    logic [31:0] rstart_reg;
    logic [31:0] rend_reg;
    logic [15:0] maxh_reg;

    reg_idx_t reg_idx;
    logic     cfg_wr;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            cursor_reg <= '0;
            fwd_reg    <= 1'b1;
            wrap_reg   <= 1'b1;
            rstart_reg <= '0;
            rend_reg   <= '1;
            maxh_reg   <= '1;
        end
        else if (cfg_wr)
        begin
            case (reg_idx)
                REG_MODE:    mode_reg   <= pwdata[0];
                REG_CURSOR:  cursor_reg <= pwdata;
                REG_FORWARD: fwd_reg    <= pwdata[0];
                REG_WRAP:    wrap_reg   <= pwdata[0];
                REG_RSTART:  rstart_reg <= pwdata;
                REG_REND:    rend_reg   <= pwdata;
                REG_MAXHITS: maxh_reg   <= pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MODE:    prdata = {31'd0, mode_reg};
            REG_CURSOR:  prdata = cursor_reg;
            REG_FORWARD: prdata = {31'd0, fwd_reg};
            REG_WRAP:    prdata = {31'd0, wrap_reg};
            REG_RSTART:  prdata = rstart_reg;
            REG_REND:    prdata = rend_reg;
            REG_MAXHITS: prdata = {16'd0, maxh_reg};
            default:     prdata = '0;
        endcase
    end

    // front stage: pattern/text loading
    func_t   in_func;
    logic [7:0] in_byte;
    assign in_func = s_tuser;
    assign in_byte = s_tdata;

    logic          s1_valid_reg;
    func_t         s1_func_reg;
    logic          s1_text_reg;
    logic [LW-1:0] plen_reg;
    logic          upper_reg;
    logic [PW-1:0] tpos_reg;
    logic          ovf_reg;
    logic          out_valid_reg;
    logic          out_free;
    logic          s2_go;
    logic          accept;
    logic          pat_shift;
    logic          win_shift;
    logic          pat_room;
    logic          pos_full;

    assign out_free  = !out_valid_reg || m_tready;
    assign s2_go     = s1_valid_reg && out_free;
    assign s_tready  = !s1_valid_reg || out_free;
    assign accept    = s_tvalid && s_tready;
    assign pat_room  = plen_reg < LW'(PATTERN_MAX);
    assign pos_full  = (tpos_reg == {PW{1'b1}});
    assign pat_shift = accept && (in_func == FUNC_PAT) && (tpos_reg == '0) && pat_room;
    assign win_shift = accept && (in_func == FUNC_TEXT) && !pos_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_func_reg  <= FUNC_CLEAR;
            s1_text_reg  <= 1'b0;
            plen_reg     <= '0;
            upper_reg    <= 1'b0;
            tpos_reg     <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_func_reg  <= in_func;
                s1_text_reg  <= win_shift;
                case (in_func)
                    FUNC_CLEAR:
                    begin
                        plen_reg  <= '0;
                        upper_reg <= 1'b0;
                        tpos_reg  <= '0;
                        ovf_reg   <= 1'b0;
                    end
                    FUNC_PAT:
                    begin
                        if (pat_shift)
                        begin
                            plen_reg <= plen_reg + LW'(1);
                            if (is_upper(in_byte))
                            begin
                                upper_reg <= 1'b1;
                            end
                        end
                        else if (tpos_reg == '0)
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                    FUNC_TEXT:
                    begin
                        if (pos_full)
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else
                        begin
                            tpos_reg <= tpos_reg + PW'(1);
                        end
                    end
                    default: ;
                endcase
            end
            else if (s2_go)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // cell chain: cell i holds pattern[len-1-i] and the text byte i beats back
    logic [7:0]             pat_q [PATTERN_MAX];
    logic [7:0]             win_q [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] eq_vec;

    genvar gi;
    generate
        for (gi = 0; gi < PATTERN_MAX; gi++)
        begin : g_cell
            logic [7:0] pin;
            logic [7:0] win;
            if (gi == 0)
            begin : g_head
                assign pin = in_byte;
                assign win = in_byte;
            end
            else
            begin : g_body
                assign pin = pat_q[gi-1];
                assign win = win_q[gi-1];
            end
            sbs_cell u_cell
            (
                .clk       (clk),
                .pat_shift (pat_shift),
                .pat_in    (pin),
                .win_shift (win_shift),
                .win_in    (win),
                .active    (plen_reg > LW'(gi)),
                .case_sens (upper_reg),
                .pat_out   (pat_q[gi]),
                .win_out   (win_q[gi]),
                .eq        (eq_vec[gi])
            );
        end
    endgenerate

    // back stage: match decision and candidates
    logic          fac_v_reg, fov_v_reg, lbc_v_reg, lov_v_reg;
    logic [PW-1:0] fac_p_reg, fov_p_reg, lbc_p_reg, lov_p_reg;
    logic [15:0]   hits_reg;
    logic [15:0]   hits_next;
    logic [CW-1:0] tpos_x;
    logic [CW-1:0] len_x;
    logic [CW-1:0] start_x;
    logic          match;
    logic          hit;

    assign tpos_x  = CW'(tpos_reg);
    assign len_x   = CW'(plen_reg);
    assign start_x = tpos_x - len_x;
    assign match   = s1_valid_reg && (s1_func_reg == FUNC_TEXT) && s1_text_reg &&
                     (plen_reg != '0) && (tpos_x >= len_x) && (&eq_vec);
    assign hit     = match && mode_reg && (start_x >= CW'(rstart_reg)) &&
                     (start_x < CW'(rend_reg)) && (hits_reg < maxh_reg);

    assign hits_next = hits_reg + 16'd1;

    // single search pick
    logic          prim_v, fb_v;
    logic [PW-1:0] prim_p, fb_p;
    logic          sel_found, sel_wrapped;
    logic [PW-1:0] sel_p;
    logic [CW-1:0] sel_x;
    logic [CW-1:0] sel_end_x;

    assign prim_v      = fwd_reg ? fac_v_reg : lbc_v_reg;
    assign prim_p      = fwd_reg ? fac_p_reg : lbc_p_reg;
    assign fb_v        = fwd_reg ? fov_v_reg : lov_v_reg;
    assign fb_p        = fwd_reg ? fov_p_reg : lov_p_reg;
    assign sel_found   = prim_v || (wrap_reg && fb_v);
    assign sel_wrapped = !prim_v && wrap_reg && fb_v;
    assign sel_p       = prim_v ? prim_p : fb_p;
    assign sel_x       = CW'(sel_p);
    assign sel_end_x   = sel_x + len_x;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fac_v_reg <= 1'b0;
            fov_v_reg <= 1'b0;
            lbc_v_reg <= 1'b0;
            lov_v_reg <= 1'b0;
            hits_reg  <= '0;
        end
        else if (s2_go)
        begin
            if (s1_func_reg == FUNC_CLEAR)
            begin
                fac_v_reg <= 1'b0;
                fov_v_reg <= 1'b0;
                lbc_v_reg <= 1'b0;
                lov_v_reg <= 1'b0;
                hits_reg  <= '0;
            end
            if (match)
            begin
                if ((start_x > CW'(cursor_reg)) && !fac_v_reg)
                begin
                    fac_v_reg <= 1'b1;
                end
                if (!fov_v_reg)
                begin
                    fov_v_reg <= 1'b1;
                end
                if (start_x < CW'(cursor_reg))
                begin
                    lbc_v_reg <= 1'b1;
                end
                lov_v_reg <= 1'b1;
            end
            if (hit)
            begin
                hits_reg <= hits_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && match)
        begin
            if ((start_x > CW'(cursor_reg)) && !fac_v_reg)
            begin
                fac_p_reg <= start_x[PW-1:0];
            end
            if (!fov_v_reg)
            begin
                fov_p_reg <= start_x[PW-1:0];
            end
            if (start_x < CW'(cursor_reg))
            begin
                lbc_p_reg <= start_x[PW-1:0];
            end
            lov_p_reg <= start_x[PW-1:0];
        end
    end

    // result register
    kind_t       out_kind_reg;
    logic        out_found_reg;
    logic        out_wrapped_reg;
    logic [31:0] out_start_reg;
    logic [31:0] out_end_reg;
    logic [15:0] out_count_reg;
    logic        out_ovf_reg;
    logic        is_end;
    logic        emit;

    assign is_end = (s1_func_reg == FUNC_END);
    assign emit   = s2_go && (hit || is_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_ovf_reg <= ovf_reg;
            if (hit)
            begin
                out_kind_reg    <= KIND_HIT;
                out_found_reg   <= 1'b0;
                out_wrapped_reg <= 1'b0;
                out_start_reg   <= start_x[31:0];
                out_end_reg     <= tpos_x[31:0];
                out_count_reg   <= hits_next;
            end
            else if (mode_reg)
            begin
                out_kind_reg    <= KIND_DONE;
                out_found_reg   <= 1'b0;
                out_wrapped_reg <= 1'b0;
                out_start_reg   <= '0;
                out_end_reg     <= '0;
                out_count_reg   <= hits_reg;
            end
            else
            begin
                out_kind_reg    <= KIND_SINGLE;
                out_found_reg   <= sel_found;
                out_wrapped_reg <= sel_wrapped;
                out_start_reg   <= sel_found ? sel_x[31:0] : 32'd0;
                out_end_reg     <= sel_found ? sel_end_x[31:0] : 32'd0;
                out_count_reg   <= '0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_ovf_reg, out_count_reg, out_end_reg, out_start_reg,
                       out_wrapped_reg, out_found_reg};

    // checks
    a_plen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        plen_reg <= LW'(PATTERN_MAX))
        else $error("pattern length beyond chain depth");

    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |=> s1_valid_reg)
        else $error("back stage dropped a beat under stall");

    a_wrap_found: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_wrapped_reg) |-> (out_found_reg && out_kind_reg == KIND_SINGLE))
        else $error("wrapped result without a single-search hit");

    a_no_text_pattern: assert property (@(posedge clk) disable iff (!rst_n)
        pat_shift |-> (tpos_reg == '0))
        else $error("pattern loaded after text");

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// tb: smartcase_buffer_search testbench
// Drives search sequences (clear, pattern, text, end of text) over the input
// stream under several register settings. Each result beat is compared field
// by field with an in-bench prediction of the search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sbs_pkg::*;

    typedef struct packed {
        func_t      func;
        logic [7:0] data;
    } beat_t;

    typedef struct packed {
        kind_t       kind;
        logic        found;
        logic        wrapped;
        logic [31:0] mstart;
        logic [31:0] mend;
        logic [15:0] hits;
        logic        ovf;
    } answer_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic [1:0]  s_tuser;   // [1:0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [87:0] m_tdata;   // found, wrapped, match_start, match_end, hit_count, overflow
    logic [1:0]  m_tuser;   // [1:0] kind
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    smartcase_buffer_search u_dut (.*);

    // register shadows
    logic        r_mode;
    logic [31:0] r_cursor;
    logic        r_fwd;
    logic        r_wrap;
    logic [31:0] r_rstart;
    logic [31:0] r_rend;
    logic [15:0] r_maxhits;

    // search state
    logic [7:0]  pat [SBS_PATTERN_MAX];
    logic [7:0]  hist [SBS_PATTERN_MAX];
    int unsigned pat_len;
    logic        pat_upper;
    logic [32:0] text_pos;
    logic        fac_v, fo_v, lbc_v, lo_v;
    logic [31:0] fac_p, fo_p, lbc_p, lo_p;
    logic [15:0] hit_cnt;
    logic        ovf_seen;

    beat_t   pend_q[$];
    answer_t answers_q[$];
    int      pushed, accepted, errors;
    int      gap, rgap, long_stall;
    bit      idle_en, long_req;
    beat_t   on_bus;

    always
    begin
        clk = 1'b0; #2;
        clk = 1'b1; #2;
    end

    function automatic logic [7:0] lc(logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic void clear_search();
        for (int i = 0; i < SBS_PATTERN_MAX; i++)
        begin
            pat[i] = 8'h00;
            hist[i] = 8'h00;
        end
        pat_len = 0; pat_upper = 0; text_pos = 0;
        fac_v = 0; fo_v = 0; lbc_v = 0; lo_v = 0;
        fac_p = 0; fo_p = 0; lbc_p = 0; lo_p = 0;
        hit_cnt = 0; ovf_seen = 0;
    endfunction

    function automatic void search_step(beat_t b);
        logic        hit;
        logic [7:0]  p, t;
        logic [31:0] st;
        answer_t     a;
        a = '0;
        case (b.func)
            FUNC_CLEAR: clear_search();
            FUNC_PAT:
                if (text_pos == 0)
                begin
                    if (pat_len >= SBS_PATTERN_MAX)
                        ovf_seen = 1;
                    else
                    begin
                        pat[pat_len] = b.data;
                        pat_len++;
                        if (b.data >= "A" && b.data <= "Z")
                            pat_upper = 1;
                    end
                end
            FUNC_TEXT:
                if (text_pos >= 33'hFFFF_FFFF)
                    ovf_seen = 1;
                else
                begin
                    for (int i = SBS_PATTERN_MAX - 1; i > 0; i--)
                        hist[i] = hist[i-1];
                    hist[0] = b.data;
                    text_pos++;
                    hit = (pat_len != 0) && (text_pos >= pat_len);
                    for (int i = 0; i < pat_len; i++)
                    begin
                        p = pat[pat_len-1-i];
                        t = hist[i];
                        if (!pat_upper)
                        begin
                            p = lc(p);
                            t = lc(t);
                        end
                        if (p != t)
                            hit = 0;
                    end
                    if (hit)
                    begin
                        st = 32'(text_pos - pat_len);
                        if (st > r_cursor && !fac_v)
                        begin
                            fac_v = 1; fac_p = st;
                        end
                        if (!fo_v)
                        begin
                            fo_v = 1; fo_p = st;
                        end
                        if (st < r_cursor)
                        begin
                            lbc_v = 1; lbc_p = st;
                        end
                        lo_v = 1; lo_p = st;
                        if (r_mode && st >= r_rstart && st < r_rend && hit_cnt < r_maxhits)
                        begin
                            hit_cnt++;
                            a.kind = KIND_HIT; a.mstart = st;
                            a.mend = st + pat_len; a.hits = hit_cnt; a.ovf = ovf_seen;
                            answers_q.push_back(a);
                        end
                    end
                end
            default:
            begin
                a.ovf = ovf_seen;
                if (r_mode)
                begin
                    a.kind = KIND_DONE; a.hits = hit_cnt;
                end
                else
                begin
                    a.kind = KIND_SINGLE;
                    if (r_fwd ? fac_v : lbc_v)
                    begin
                        a.found = 1; a.mstart = r_fwd ? fac_p : lbc_p;
                    end
                    else if (r_wrap && (r_fwd ? fo_v : lo_v))
                    begin
                        a.found = 1; a.wrapped = 1; a.mstart = r_fwd ? fo_p : lo_p;
                    end
                    if (a.found)
                        a.mend = a.mstart + pat_len;
                end
                answers_q.push_back(a);
            end
        endcase
    endfunction

    // input driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tuser  <= FUNC_CLEAR;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                search_step(on_bus);
                accepted++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (gap > 0)
                begin
                    gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pend_q.size() > 0)
                begin
                    on_bus = pend_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= on_bus.data;
                    s_tuser  <= on_bus.func;
                    if (idle_en && $urandom_range(0, 7) == 0)
                        gap = $urandom_range(1, 9);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got, exp_a;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind = m_tuser;
                {got.ovf, got.hits, got.mend, got.mstart, got.wrapped, got.found} = m_tdata[82:0];
                if (answers_q.size() == 0)
                begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errors++;
                end
                else
                begin
                    exp_a = answers_q.pop_front();
                    if (got.kind != exp_a.kind)
                    begin
                        $error("kind: expected %0d got %0d", exp_a.kind, got.kind); errors++;
                    end
                    if (got.found != exp_a.found)
                    begin
                        $error("found: expected %0d got %0d", exp_a.found, got.found); errors++;
                    end
                    if (got.wrapped != exp_a.wrapped)
                    begin
                        $error("wrapped: expected %0d got %0d", exp_a.wrapped, got.wrapped);
                        errors++;
                    end
                    if (got.mstart != exp_a.mstart)
                    begin
                        $error("match_start: expected %0d got %0d", exp_a.mstart, got.mstart);
                        errors++;
                    end
                    if (got.mend != exp_a.mend)
                    begin
                        $error("match_end: expected %0d got %0d", exp_a.mend, got.mend); errors++;
                    end
                    if (got.hits != exp_a.hits)
                    begin
                        $error("hit_count: expected %0d got %0d", exp_a.hits, got.hits); errors++;
                    end
                    if (got.ovf != exp_a.ovf)
                    begin
                        $error("overflow: expected %0d got %0d", exp_a.ovf, got.ovf); errors++;
                    end
                end
            end
            if (long_req)
            begin
                long_req = 0;
                long_stall = 400;
            end
            if (long_stall > 0)
            begin
                long_stall--;
                m_tready <= 1'b0;
            end
            else if (rgap > 0)
            begin
                rgap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_en && $urandom_range(0, 7) == 0)
                    rgap = $urandom_range(1, 9);
            end
        end
    end

    // timeout
    int cycles;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_item(func_t f, logic [7:0] d);
        beat_t b;
        b.func = f;
        b.data = d;
        pend_q.push_back(b);
        pushed++;
    endtask

    task automatic wait_idle();
        while (accepted != pushed || answers_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic reg_write(reg_idx_t idx, logic [31:0] v);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx * 4); pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_MODE:    r_mode = v[0];
            REG_CURSOR:  r_cursor = v;
            REG_FORWARD: r_fwd = v[0];
            REG_WRAP:    r_wrap = v[0];
            REG_RSTART:  r_rstart = v;
            REG_REND:    r_rend = v;
            REG_MAXHITS: r_maxhits = v[15:0];
            default:     ;
        endcase
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 9))
            0, 1:    return "a";
            2, 3:    return "A";
            4:       return "b";
            5:       return "B";
            6:       return "@";
            7:       return "[";
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [31:0] pick_pos();
        case ($urandom_range(0, 4))
            0:       return 32'h0;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom_range(0, 40);
        endcase
    endfunction

    // one search: optional clear, pattern, text with optional mid-stream answers, end
    task automatic gen_search();
        int plen, tlen;
        if ($urandom_range(0, 9) != 0)
            push_item(FUNC_CLEAR, 8'($urandom));
        plen = ($urandom_range(0, 30) == 0) ? $urandom_range(60, 68) : $urandom_range(0, 3);
        repeat (plen) push_item(FUNC_PAT, pick_char());
        tlen = $urandom_range(0, 24);
        for (int i = 0; i < tlen; i++)
        begin
            case ($urandom_range(0, 19))
                0:       push_item(FUNC_END, 8'($urandom));
                1:       push_item(FUNC_PAT, pick_char());
                default: push_item(FUNC_TEXT, pick_char());
            endcase
        end
        push_item(FUNC_END, 8'($urandom));
    endtask

    initial
    begin
        int i;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        pushed = 0; accepted = 0; errors = 0; cycles = 0;
        gap = 0; rgap = 0; long_stall = 0; long_req = 0; idle_en = 1;
        r_mode = 0; r_cursor = 0; r_fwd = 1; r_wrap = 1;
        r_rstart = 0; r_rend = 32'hFFFF_FFFF; r_maxhits = 16'hFFFF;
        clear_search();
        rst_n = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;

        // directed: defaults, empty pattern, folded, case-sensitive, overlap
        push_item(FUNC_END, 8'hFF);
        push_item(FUNC_PAT, "a");
        push_item(FUNC_TEXT, 8'h00);
        push_item(FUNC_TEXT, "A");
        push_item(FUNC_TEXT, "a");
        push_item(FUNC_PAT, "x");
        push_item(FUNC_END, 8'h00);
        push_item(FUNC_CLEAR, 8'hFF);
        push_item(FUNC_PAT, "A");
        push_item(FUNC_PAT, "A");
        for (i = 0; i < 5; i++)
            push_item(FUNC_TEXT, (i == 3) ? 8'h61 : 8'h41);
        push_item(FUNC_END, 8'h00);
        push_item(FUNC_TEXT, 8'hFF);
        push_item(FUNC_END, 8'h00);
        wait_idle();

        reg_write(REG_MODE, 1);
        reg_write(REG_RSTART, 1);
        reg_write(REG_REND, 3);
        reg_write(REG_MAXHITS, 16'hFFFF);
        push_item(FUNC_CLEAR, 0);
        push_item(FUNC_PAT, "b");
        for (i = 0; i < 6; i++)
            push_item(FUNC_TEXT, "B");
        push_item(FUNC_END, 0);
        wait_idle();

        // receiver holds off while hits pile up
        reg_write(REG_RSTART, 0);
        reg_write(REG_REND, 32'hFFFF_FFFF);
        long_req = 1;
        push_item(FUNC_CLEAR, 0);
        push_item(FUNC_PAT, "a");
        for (i = 0; i < 60; i++)
            push_item(FUNC_TEXT, "a");
        push_item(FUNC_END, 0);
        wait_idle();

        for (int ph = 0; ph < 12; ph++)
        begin
            if (ph == 10)
                idle_en = 0;
            reg_write(REG_MODE, $urandom_range(0, 1));
            reg_write(REG_CURSOR, pick_pos());
            reg_write(REG_FORWARD, $urandom_range(0, 1));
            reg_write(REG_WRAP, $urandom_range(0, 1));
            reg_write(REG_RSTART, pick_pos());
            reg_write(REG_REND, pick_pos());
            case ($urandom_range(0, 3))
                0:       reg_write(REG_MAXHITS, 0);
                1:       reg_write(REG_MAXHITS, 16'hFFFF);
                default: reg_write(REG_MAXHITS, $urandom_range(1, 5));
            endcase
            while (pushed < 95 * (ph + 1) + 120)
                gen_search();
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (errors == 0 && answers_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
